FILE: sv/pcsi_pkg.sv
// Shared types and constants for the PCF clock synchronization block.
// Holds opcodes, register indexes, configuration, command and result structs.
// No dependencies.
`default_nettype none

package pcsi_pkg;

    localparam int TIME_W  = 64;
    localparam int CNT_W   = 32;
    localparam int FCNT_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int DIV_W   = 17;
    localparam int Q_SHIFT = 10;
    localparam int MUL_W   = (GAIN_W + 1) + (TIME_W / 2 + 1);
    localparam int PROD_W  = TIME_W + Q_SHIFT;

    // request opcodes
    localparam logic [1:0] OP_FRAME   = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_ALIGN   = 2'd2;

    // register word indexes
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_PRECISION     = 3'd2;
    localparam logic [2:0] REG_MAX_DELAY     = 3'd3;
    localparam logic [2:0] REG_DIVISOR       = 3'd4;
    localparam logic [2:0] REG_STABLE_THR    = 3'd5;
    localparam logic [2:0] REG_CORR_EN       = 3'd6;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integral_gain;
        logic [CNT_W-1:0]  precision_ns;
        logic [CNT_W-1:0]  max_delay_ns;
        logic [DIV_W-1:0]  clock_divisor;
        logic [15:0]       stable_threshold;
        logic              correction_enable;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       timeout;
        logic       perm;
        logic       update;
        logic       accum;
        logic       flags;
        logic       mul;
        logic       macc;
        logic       msum;
        logic       align;
        logic       out_load;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

    typedef struct packed {
        logic              cold_start;
        logic              sync_stable;
        logic              integrated;
        logic              frame_used;
        logic              in_window;
        logic [TIME_W-1:0] clock_offset;
        logic [TIME_W-1:0] aligned_time;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/pcsi_div.sv
// Iterative unsigned divider, 64-bit dividend by 17-bit divisor, two bits a cycle.
// Used by the datapath for the transparent clock scaling; uses pcsi_pkg widths.
`default_nettype none

module pcsi_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pcsi_pkg::TIME_W-1:0]   dividend,
    input  wire logic [pcsi_pkg::DIV_W-1:0]    divisor,
    output logic      [pcsi_pkg::TIME_W-1:0]   quotient,
    output logic                               done
);

    localparam int DW    = pcsi_pkg::DIV_W;
    localparam int TW    = pcsi_pkg::TIME_W;
    localparam int STEPS = TW / 2;
    localparam int CW    = $clog2(STEPS);

    function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                             input logic [DW-1:0] d);
        logic [DW:0] t;
        logic [DW:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            div_step = {diff[DW-1:0], 1'b1};
        else
            div_step = {t[DW-1:0], 1'b0};
    endfunction

    logic [DW-1:0] rem_reg, rem_next;
    logic [TW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] d_eff;
    logic [DW:0]   s_a;
    logic [DW:0]   s_b;

    // a zero divisor acts as one
    assign d_eff = (divisor == '0) ? DW'(1) : divisor;

    always_comb
    begin
        s_a      = div_step(rem_reg, quo_reg[TW-1], d_eff);
        s_b      = div_step(s_a[DW:1], quo_reg[TW-2], d_eff);
        rem_next = s_b[DW:1];
        quo_next = {quo_reg[TW-3:0], s_a[0], s_b[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: sv/pcsi_dp.sv
// Datapath: synchronization state, permanence point, window test, flags and
// the shared 17x33 multiplier for the PI correction. Uses pcsi_pkg and pcsi_div.
`default_nettype none

module pcsi_dp
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pcsi_pkg::cmd_t                    cmd,
    input  wire pcsi_pkg::cfg_t                    cfg,
    input  wire logic [pcsi_pkg::TIME_W-1:0]       receive_time_ns,
    input  wire logic [pcsi_pkg::TIME_W-1:0]       schedule_start_ns,
    input  wire logic [pcsi_pkg::TIME_W-1:0]       expected_point_ns,
    input  wire logic [pcsi_pkg::TIME_W-1:0]       transparent_clock,
    input  wire logic [pcsi_pkg::FCNT_W-1:0]       sync_cycle,
    input  wire logic [pcsi_pkg::TIME_W-1:0]       time_value,
    output pcsi_pkg::sts_t                         sts,
    output pcsi_pkg::res_t                         res
);

    localparam int TW  = pcsi_pkg::TIME_W;
    localparam int NW  = pcsi_pkg::CNT_W;
    localparam int FW  = pcsi_pkg::FCNT_W;
    localparam int MW  = pcsi_pkg::MUL_W;
    localparam int PW  = pcsi_pkg::PROD_W;
    localparam int HW  = TW / 2;
    localparam int GW  = pcsi_pkg::GAIN_W;
    localparam int QS  = pcsi_pkg::Q_SHIFT;

    // synchronization state
    logic [TW-1:0] offset_reg;
    logic [TW-1:0] sum_reg;
    logic [NW-1:0] in_cnt_reg, out_cnt_reg;
    logic [NW-1:0] in_clu_reg, out_clu_reg;
    logic [FW-1:0] frame_cnt_reg;
    logic          cold_reg, first_reg, integ_reg, stable_reg;

    // request and work registers
    logic [TW-1:0] rx_reg, start_reg, expct_reg, time_reg;
    logic [FW-1:0] ic_reg;
    logic [TW-1:0] perm_reg, wlo_reg, whi_reg;
    logic signed [MW-1:0] mul_reg;
    logic [PW-1:0] prod_reg;
    logic [TW-1:0] corr_reg;
    logic [TW-1:0] aligned_reg;
    logic          win_reg, used_reg;

    logic [TW-1:0] tc_q;
    logic          div_done;
    logic          ic_zero;
    logic          gate;
    logic          in_win;
    logic [TW-1:0] mag;
    logic [NW-1:0] wdiff, cdiff;
    logic          wpos, cgt, integ_new;
    logic [GW-1:0] gain;
    logic [TW-1:0] mval;
    logic signed [GW:0]   mul_a;
    logic signed [HW:0]   mul_b;
    logic signed [MW-1:0] mul_p;

    pcsi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (transparent_clock),
        .divisor  (cfg.clock_divisor),
        .quotient (tc_q),
        .done     (div_done)
    );

    assign sts.div_done = div_done;

    assign ic_zero = (ic_reg == '0);
    assign gate    = !cold_reg || ic_zero;
    assign in_win  = (perm_reg > wlo_reg) && (perm_reg < whi_reg);

    assign mag     = offset_reg[TW-1] ? (~offset_reg + TW'(1)) : offset_reg;
    assign wdiff   = in_cnt_reg - out_cnt_reg;
    assign cdiff   = in_clu_reg - out_clu_reg;
    assign wpos    = !wdiff[NW-1] && (wdiff != '0);
    assign cgt     = $signed(cdiff) > $signed({{(NW-16){1'b0}}, cfg.stable_threshold});
    assign integ_new = !cold_reg && wpos && (mag < {{(TW-NW){1'b0}}, cfg.precision_ns});

    // sel[1] picks the gain and its operand, sel[0] the upper half of the operand
    assign gain  = cmd.sel[1] ? cfg.integral_gain : cfg.prop_gain;
    assign mval  = cmd.sel[1] ? sum_reg : offset_reg;
    assign mul_a = $signed({gain[GW-1], gain});
    assign mul_b = cmd.sel[0] ? $signed({mval[TW-1], mval[TW-1:HW]})
                              : $signed({1'b0, mval[HW-1:0]});
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            sum_reg       <= '0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            in_clu_reg    <= '0;
            out_clu_reg   <= '0;
            frame_cnt_reg <= '0;
            cold_reg      <= 1'b1;
            first_reg     <= 1'b1;
            integ_reg     <= 1'b0;
            stable_reg    <= 1'b0;
        end
        else if (cmd.timeout)
        begin
            first_reg  <= 1'b1;
            cold_reg   <= 1'b1;
            integ_reg  <= 1'b0;
            stable_reg <= 1'b0;
            offset_reg <= '0;
            sum_reg    <= '0;
        end
        else if (cmd.update)
        begin
            if (gate)
            begin
                cold_reg   <= 1'b0;
                offset_reg <= perm_reg - expct_reg;
                if (in_win)
                begin
                    in_cnt_reg <= in_cnt_reg + NW'(1);
                    if (ic_zero)
                        in_clu_reg <= in_clu_reg + NW'(1);
                end
                else
                begin
                    out_cnt_reg <= out_cnt_reg + NW'(1);
                    if (ic_zero)
                        out_clu_reg <= out_clu_reg + NW'(1);
                end
            end
        end
        else if (cmd.accum)
        begin
            if (used_reg)
                sum_reg <= sum_reg + offset_reg;
        end
        else if (cmd.flags)
        begin
            integ_reg     <= integ_new;
            frame_cnt_reg <= frame_cnt_reg + FW'(1);
            // the first stable decision waits for an integrated cluster frame
            if ((first_reg && ic_zero && integ_new) || !first_reg)
            begin
                stable_reg <= integ_new && cgt;
                first_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rx_reg      <= receive_time_ns;
            start_reg   <= schedule_start_ns;
            expct_reg   <= expected_point_ns;
            ic_reg      <= sync_cycle;
            time_reg    <= time_value;
            corr_reg    <= '0;
            aligned_reg <= '0;
            win_reg     <= 1'b0;
            used_reg    <= 1'b0;
        end
        if (cmd.perm)
        begin
            perm_reg <= rx_reg - start_reg + ({{(TW-NW){1'b0}}, cfg.max_delay_ns} - tc_q);
            wlo_reg  <= expct_reg - {{(TW-NW){1'b0}}, cfg.precision_ns};
            whi_reg  <= expct_reg + {{(TW-NW){1'b0}}, cfg.precision_ns};
        end
        if (cmd.update && gate)
        begin
            used_reg <= 1'b1;
            win_reg  <= in_win;
        end
        if (cmd.mul)
            mul_reg <= mul_p;
        if (cmd.macc)
        begin
            if (cmd.sel[0])
                prod_reg <= prod_reg + {mul_reg[PW-HW-1:0], {HW{1'b0}}};
            else
                prod_reg <= {{(PW-MW){mul_reg[MW-1]}}, mul_reg};
        end
        if (cmd.msum)
            corr_reg <= corr_reg + prod_reg[PW-1:QS];
        if (cmd.align)
            aligned_reg <= cfg.correction_enable ? (time_reg + corr_reg) : time_reg;
    end

    assign res.aligned_time = aligned_reg;
    assign res.clock_offset = offset_reg;
    assign res.in_window    = win_reg;
    assign res.frame_used   = used_reg;
    assign res.integrated   = integ_reg;
    assign res.sync_stable  = stable_reg;
    assign res.cold_start   = cold_reg;

    a_win_used: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg |-> used_reg)
        else $error("in-window result without frame use");

    a_integ_cold: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg |-> !cold_reg)
        else $error("integrated while in cold start");

    a_stable_integ: assert property (@(posedge clk) disable iff (!rst_n)
        stable_reg |-> integ_reg)
        else $error("stable without integration");

endmodule

`default_nettype wire

FILE: sv/pcsi_ctrl.sv
// Controller state machine: sequences divider, frame update steps, the four
// partial products of the PI correction and the result hand-off. Uses pcsi_pkg.
`default_nettype none

module pcsi_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        op,
    input  wire logic              out_free,
    input  wire pcsi_pkg::sts_t    sts,
    output pcsi_pkg::cmd_t         cmd,
    output logic                   ready
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DIV   = 11'b000_0000_0010,
        S_PERM  = 11'b000_0000_0100,
        S_UPD   = 11'b000_0000_1000,
        S_ACCUM = 11'b000_0001_0000,
        S_FLAGS = 11'b000_0010_0000,
        S_MUL   = 11'b000_0100_0000,
        S_MACC  = 11'b000_1000_0000,
        S_MSUM  = 11'b001_0000_0000,
        S_ALIGN = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    localparam logic [1:0] STEP_LAST = 2'd3;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.sel    = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (op)
                        pcsi_pkg::OP_FRAME:
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                        pcsi_pkg::OP_TIMEOUT:
                        begin
                            cmd.timeout = 1'b1;
                            state_next  = S_OUT;
                        end
                        pcsi_pkg::OP_ALIGN:
                        begin
                            step_next  = '0;
                            state_next = S_MUL;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_PERM;
            end
            S_PERM:
            begin
                cmd.perm   = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = S_FLAGS;
            end
            S_FLAGS:
            begin
                cmd.flags  = 1'b1;
                state_next = S_OUT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                cmd.macc = 1'b1;
                // upper half done: fold the product into the correction
                if (step_reg[0])
                    state_next = S_MSUM;
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_MSUM:
            begin
                cmd.msum = 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_ALIGN;
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign ready = (state_reg == S_IDLE);

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded into a full output register");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start work");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == S_DIV))
        else $error("divider started outside the divide wait");

endmodule

`default_nettype wire

FILE: sv/pcf_clock_sync_integration.sv
// Frame request: divider, then permanence point, update, accumulate and flags steps.
// Align request: four 17x33 partial products on one multiplier; others skip to output.
// One request in work at a time; the next is taken once the controller is idle, even while
// a result waits for the sink.
// rst_n clears synchronization state and flags and sets configuration to its reset values.
// Top level: APB register file, stream handshake, output register; uses pcsi_pkg.
`default_nettype none

module pcf_clock_sync_integration
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // receive_time_ns, schedule_start_ns, expected_point_ns, transparent_clock,
    // sync_cycle, time_value
    input  wire logic [335:0] s_tdata,
    // opcode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // aligned_time, clock_offset, in_window, frame_used, integrated, sync_stable,
    // cold_start, zero pad
    output logic [135:0]      m_tdata
);

    pcsi_pkg::cfg_t cfg_reg;
    pcsi_pkg::cmd_t cmd;
    pcsi_pkg::sts_t sts;
    pcsi_pkg::res_t res;

    logic         wr_en;
    logic [2:0]   wr_idx;
    logic         ready;
    logic         start;
    logic         out_free;
    logic         m_tvalid_reg;
    logic [135:0] m_tdata_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain         <= '0;
            cfg_reg.integral_gain     <= '0;
            cfg_reg.precision_ns      <= 32'd10000;
            cfg_reg.max_delay_ns      <= '0;
            cfg_reg.clock_divisor     <= 17'h10000;
            cfg_reg.stable_threshold  <= 16'd10;
            cfg_reg.correction_enable <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                pcsi_pkg::REG_PROP_GAIN:     cfg_reg.prop_gain         <= pwdata[15:0];
                pcsi_pkg::REG_INTEGRAL_GAIN: cfg_reg.integral_gain     <= pwdata[15:0];
                pcsi_pkg::REG_PRECISION:     cfg_reg.precision_ns      <= pwdata;
                pcsi_pkg::REG_MAX_DELAY:     cfg_reg.max_delay_ns      <= pwdata;
                pcsi_pkg::REG_DIVISOR:       cfg_reg.clock_divisor     <= pwdata[16:0];
                pcsi_pkg::REG_STABLE_THR:    cfg_reg.stable_threshold  <= pwdata[15:0];
                pcsi_pkg::REG_CORR_EN:       cfg_reg.correction_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            pcsi_pkg::REG_PROP_GAIN:     prdata = {16'd0, cfg_reg.prop_gain};
            pcsi_pkg::REG_INTEGRAL_GAIN: prdata = {16'd0, cfg_reg.integral_gain};
            pcsi_pkg::REG_PRECISION:     prdata = cfg_reg.precision_ns;
            pcsi_pkg::REG_MAX_DELAY:     prdata = cfg_reg.max_delay_ns;
            pcsi_pkg::REG_DIVISOR:       prdata = {15'd0, cfg_reg.clock_divisor};
            pcsi_pkg::REG_STABLE_THR:    prdata = {16'd0, cfg_reg.stable_threshold};
            pcsi_pkg::REG_CORR_EN:       prdata = {31'd0, cfg_reg.correction_enable};
            default:                     prdata = '0;
        endcase
    end

    assign s_tready = ready;
    assign start    = s_tvalid && ready;
    assign out_free = !m_tvalid_reg || m_tready;

    pcsi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (s_tuser),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .ready    (ready)
    );

    pcsi_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg_reg),
        .receive_time_ns   (s_tdata[63:0]),
        .schedule_start_ns (s_tdata[127:64]),
        .expected_point_ns (s_tdata[191:128]),
        .transparent_clock (s_tdata[255:192]),
        .sync_cycle        (s_tdata[271:256]),
        .time_value        (s_tdata[335:272]),
        .sts               (sts),
        .res               (res)
    );

    // hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            m_tdata_reg <= {3'd0, res.cold_start, res.sync_stable, res.integrated,
                            res.frame_used, res.in_window, res.clock_offset,
                            res.aligned_time};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: verif/pcf_clock_sync_integration_tb.sv
// Self-checking testbench for the PCF clock synchronization block: stream requests in,
// stream status out, APB register writes between phases. Expected status comes from a typed
// row or the in-bench sync predictor. Depends on pcsi_pkg and pcf_clock_sync_integration.
`timescale 1ns / 1ps

module pcf_clock_sync_integration_tb;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] rt;
        logic [63:0] ss;
        logic [63:0] ep;
        logic [63:0] tcl;
        logic [15:0] ic;
        logic [63:0] tv;
    } pcf_req_t;

    typedef struct packed {
        pcf_req_t       req;
        logic           typed;
        pcsi_pkg::res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid;
    logic s_tready;
    // receive_time_ns, schedule_start_ns, expected_point_ns, transparent_clock,
    // sync_cycle, time_value
    logic [335:0] s_tdata;
    // opcode
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    // aligned_time, clock_offset, in_window, frame_used, integrated, sync_stable,
    // cold_start, zero pad
    logic [135:0] m_tdata;

    // register shadow
    logic [15:0] cfg_prop  = 16'd0;
    logic [15:0] cfg_integ = 16'd0;
    logic [31:0] cfg_prec  = 32'd10000;
    logic [31:0] cfg_maxd  = 32'd0;
    logic [16:0] cfg_div   = 17'd65536;
    logic [15:0] cfg_thr   = 16'd10;
    logic        cfg_en    = 1'b1;

    // synchronization state
    logic [63:0] sync_offset = '0;
    logic [63:0] sync_sum    = '0;
    logic [31:0] win_in  = '0;
    logic [31:0] win_out = '0;
    logic [31:0] clu_in  = '0;
    logic [31:0] clu_out = '0;
    logic sync_cold  = 1'b1;
    logic sync_first = 1'b1;
    logic sync_integ = 1'b0;
    logic sync_stab  = 1'b0;

    pcsi_pkg::res_t awaited_status[$];
    stim_row_t      stim_rows[$];
    int             mismatches = 0;
    int             tx_calm = 0;
    int             idle_cycles = 0;

    pcf_clock_sync_integration dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // floor(gain * val / 2^10), low 64 bits of the full product
    function automatic logic [63:0] q10_scale(input logic [15:0] gain, input logic [63:0] val);
        logic signed [80:0] g;
        logic signed [80:0] v;
        logic signed [80:0] p;
        g = $signed(gain);
        v = $signed(val);
        p = (g * v) >>> pcsi_pkg::Q_SHIFT;
        return p[63:0];
    endfunction

    function automatic pcsi_pkg::res_t predict_sync(input pcf_req_t r);
        pcsi_pkg::res_t o;
        logic [63:0]    div_eff;
        logic [63:0]    perm;
        logic [63:0]    mag;
        logic [63:0]    corr;
        int             d_win;
        int             d_clu;
        int             thr_i;
        o = '0;
        case (r.op)
            pcsi_pkg::OP_FRAME:
            begin
                div_eff = (cfg_div == 17'd0) ? 64'd1 : {47'd0, cfg_div};
                perm = r.rt - r.ss + ({32'd0, cfg_maxd} - r.tcl / div_eff);
                if (!sync_cold || r.ic == 16'd0)
                begin
                    o.frame_used = 1'b1;
                    sync_cold = 1'b0;
                    sync_offset = perm - r.ep;
                    sync_sum = sync_sum + sync_offset;
                    if (perm > r.ep - {32'd0, cfg_prec} && perm < r.ep + {32'd0, cfg_prec})
                    begin
                        o.in_window = 1'b1;
                        win_in = win_in + 1;
                        if (r.ic == 16'd0)
                            clu_in = clu_in + 1;
                    end
                    else
                    begin
                        win_out = win_out + 1;
                        if (r.ic == 16'd0)
                            clu_out = clu_out + 1;
                    end
                end
                mag = sync_offset[63] ? -sync_offset : sync_offset;
                d_win = win_in - win_out;
                sync_integ = !sync_cold && d_win > 0 && mag < {32'd0, cfg_prec};
                // stability is only judged once the first cluster frame integrated
                if ((sync_first && r.ic == 16'd0 && sync_integ) || !sync_first)
                begin
                    d_clu = clu_in - clu_out;
                    thr_i = int'(cfg_thr);
                    sync_stab = sync_integ && d_clu > thr_i;
                    sync_first = 1'b0;
                end
            end
            pcsi_pkg::OP_TIMEOUT:
            begin
                sync_first = 1'b1;
                sync_cold = 1'b1;
                sync_integ = 1'b0;
                sync_stab = 1'b0;
                sync_offset = '0;
                sync_sum = '0;
            end
            pcsi_pkg::OP_ALIGN:
            begin
                corr = q10_scale(cfg_prop, sync_offset) + q10_scale(cfg_integ, sync_sum);
                o.aligned_time = cfg_en ? r.tv + corr : r.tv;
            end
            default:
            begin
            end
        endcase
        o.clock_offset = sync_offset;
        o.integrated = sync_integ;
        o.sync_stable = sync_stab;
        o.cold_start = sync_cold;
        return o;
    endfunction

    function automatic int pick_wait(inout int calm);
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(19, 0) == 0)
        begin
            calm = $urandom_range(40, 10);
            return 0;
        end
        return $urandom_range(9, 0);
    endfunction

    // status with everything cleared, as after reset or a timeout
    function automatic pcsi_pkg::res_t cleared_status(input logic [63:0] aligned);
        pcsi_pkg::res_t o;
        o = '0;
        o.cold_start = 1'b1;
        o.aligned_time = aligned;
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic pcf_req_t random_request();
        pcf_req_t    r;
        int          pick;
        int          kind;
        logic [63:0] div_eff;
        logic [63:0] off;
        logic [63:0] m;
        r.op = pcsi_pkg::OP_FRAME;
        r.rt = rand64();
        r.ss = rand64();
        r.ep = rand64();
        r.tcl = rand64();
        r.ic = 16'($urandom);
        r.tv = rand64();
        pick = $urandom_range(99, 0);
        if (pick < 12)
        begin
            r.op = pcsi_pkg::OP_ALIGN;
            kind = $urandom_range(9, 0);
            if (kind == 0)
                r.tv = '0;
            else if (kind == 1)
                r.tv = '1;
        end
        else if (pick < 16)
            r.op = pcsi_pkg::OP_TIMEOUT;
        else if (pick < 19)
            r.op = OP_UNUSED;
        else if (pick >= 27)
        begin
            // well-formed frame aimed at a chosen offset
            kind = $urandom_range(9, 0);
            r.ic = (kind < 6) ? 16'd0 : (kind < 9) ? 16'($urandom_range(7, 1)) : 16'($urandom);
            if ($urandom_range(1, 0))
                r.ss = {32'd0, $urandom};
            if ($urandom_range(3, 0) != 0)
                r.ep = {32'd0, $urandom};
            div_eff = (cfg_div == 17'd0) ? 64'd1 : {47'd0, cfg_div};
            if ($urandom_range(1, 0))
                r.tcl = {32'd0, 32'($urandom_range(1000, 0))} * div_eff
                        + 64'($urandom_range(3, 0));
            kind = $urandom_range(99, 0);
            if (kind < 70)
                m = (cfg_prec > 32'd1) ? {32'd0, 32'($urandom_range(cfg_prec - 1, 0))} : '0;
            else if (kind < 80)
                m = {32'd0, cfg_prec};
            else if (kind < 90)
                m = (cfg_prec > 32'd0) ? {32'd0, cfg_prec - 32'd1} : '0;
            else if (kind < 95)
                m = 64'h8000_0000_0000_0000;
            else
                m = rand64();
            off = $urandom_range(1, 0) ? -m : m;
            r.rt = r.ep + off + r.ss - ({32'd0, cfg_maxd} - r.tcl / div_eff);
        end
        return r;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [63:0] rt, input logic [63:0] ss,
                           input logic [63:0] ep, input logic [63:0] tcl, input logic [15:0] ic,
                           input logic [63:0] tv, input logic typed,
                           input pcsi_pkg::res_t want);
        stim_row_t row;
        row.req.op = op;
        row.req.rt = rt;
        row.req.ss = ss;
        row.req.ep = ep;
        row.req.tcl = tcl;
        row.req.ic = ic;
        row.req.tv = tv;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endtask

    task automatic build_directed();
        int k;
        add_row(pcsi_pkg::OP_ALIGN, '0, '0, '0, '0, 16'd0, '1, 1'b1, cleared_status('1));
        add_row(OP_UNUSED, '1, '1, '1, '1, 16'hFFFF, '1, 1'b1, cleared_status('0));
        // cold gate blocks a frame from outside the cluster
        add_row(pcsi_pkg::OP_FRAME, '1, '1, '1, '1, 16'hFFFF, '1, 1'b1, cleared_status('0));
        add_row(pcsi_pkg::OP_TIMEOUT, '0, '0, '0, '0, 16'd0, '0, 1'b1, cleared_status('0));
        add_row(pcsi_pkg::OP_FRAME, 64'd1000000, '0, 64'd1000000, '0, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_FRAME, 64'd1000050, '0, 64'd1000000, '0, 16'd1, '0, 1'b0, '0);
        // window edges are exclusive
        add_row(pcsi_pkg::OP_FRAME, 64'd1010000, '0, 64'd1000000, '0, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_FRAME, 64'd990000, '0, 64'd1000000, '0, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_FRAME, 64'd1009999, '0, 64'd1000000, '0, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_FRAME, 64'd1000007, '0, 64'd1000000, 64'd458752, 16'd0, '0,
                1'b0, '0);
        add_row(pcsi_pkg::OP_FRAME, '1, '0, '0, '1, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_FRAME, '0, '1, '1, '0, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_FRAME, 64'h8000_0000_0000_0000, '0, '0, '0, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_ALIGN, '0, '0, '0, '0, 16'd0, '0, 1'b0, '0);
        add_row(OP_UNUSED, '0, '0, '0, '0, 16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_TIMEOUT, '1, '1, '1, '1, 16'hFFFF, '1, 1'b1, cleared_status('0));
        add_row(pcsi_pkg::OP_ALIGN, '0, '0, '0, '0, 16'd0, 64'h0123_4567_89AB_CDEF, 1'b1,
                cleared_status(64'h0123_4567_89AB_CDEF));
        add_row(pcsi_pkg::OP_FRAME, 64'd5000, '0, 64'd5000, '0, 16'd5, '0, 1'b1,
                cleared_status('0));
        for (k = 0; k < 6; k++)
            add_row(pcsi_pkg::OP_FRAME, 64'd2000000 + 64'(3 * k), 64'd100, 64'd1999900, '0,
                    16'd0, '0, 1'b0, '0);
        add_row(pcsi_pkg::OP_ALIGN, '0, '0, '0, '0, 16'd0, 64'hFEDC_BA98_7654_3210, 1'b0, '0);
    endtask

    task automatic push_request(input pcf_req_t r, input logic typed,
                                input pcsi_pkg::res_t want);
        int w;
        w = pick_wait(tx_calm);
        if (w > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.tv, r.ic, r.tcl, r.ep, r.ss, r.rt};
        s_tuser <= r.op;
        do @(posedge clk); while (!s_tready);
        // valid stays high; the next call drops it if it waits
        if (typed)
        begin
            void'(predict_sync(r));
            awaited_status.push_back(want);
        end
        else
            awaited_status.push_back(predict_sync(r));
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            pcsi_pkg::REG_PROP_GAIN:     cfg_prop = val[15:0];
            pcsi_pkg::REG_INTEGRAL_GAIN: cfg_integ = val[15:0];
            pcsi_pkg::REG_PRECISION:     cfg_prec = val;
            pcsi_pkg::REG_MAX_DELAY:     cfg_maxd = val;
            pcsi_pkg::REG_DIVISOR:       cfg_div = val[16:0];
            pcsi_pkg::REG_STABLE_THR:    cfg_thr = val[15:0];
            pcsi_pkg::REG_CORR_EN:       cfg_en = val[0];
            default:                     ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] prop, input logic [15:0] integ,
                                input logic [31:0] prec, input logic [31:0] maxd,
                                input logic [16:0] div, input logic [15:0] thr, input logic en);
        apb_write(pcsi_pkg::REG_PROP_GAIN, {16'd0, prop});
        apb_write(pcsi_pkg::REG_INTEGRAL_GAIN, {16'd0, integ});
        apb_write(pcsi_pkg::REG_PRECISION, prec);
        apb_write(pcsi_pkg::REG_MAX_DELAY, maxd);
        apb_write(pcsi_pkg::REG_DIVISOR, {15'd0, div});
        apb_write(pcsi_pkg::REG_STABLE_THR, {16'd0, thr});
        apb_write(pcsi_pkg::REG_CORR_EN, {31'd0, en});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // drop valid, wait for every result, then let the block go quiet
    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) push_request(random_request(), 1'b0, '0);
    endtask

    task automatic compare_status(input pcsi_pkg::res_t want, input pcsi_pkg::res_t got);
        if (got.aligned_time !== want.aligned_time)
        begin
            $error("aligned_time: expected %h, got %h", want.aligned_time, got.aligned_time);
            mismatches++;
        end
        if (got.clock_offset !== want.clock_offset)
        begin
            $error("clock_offset: expected %h, got %h", want.clock_offset, got.clock_offset);
            mismatches++;
        end
        if (got.in_window !== want.in_window)
        begin
            $error("in_window: expected %b, got %b", want.in_window, got.in_window);
            mismatches++;
        end
        if (got.frame_used !== want.frame_used)
        begin
            $error("frame_used: expected %b, got %b", want.frame_used, got.frame_used);
            mismatches++;
        end
        if (got.integrated !== want.integrated)
        begin
            $error("integrated: expected %b, got %b", want.integrated, got.integrated);
            mismatches++;
        end
        if (got.sync_stable !== want.sync_stable)
        begin
            $error("sync_stable: expected %b, got %b", want.sync_stable, got.sync_stable);
            mismatches++;
        end
        if (got.cold_start !== want.cold_start)
        begin
            $error("cold_start: expected %b, got %b", want.cold_start, got.cold_start);
            mismatches++;
        end
    endtask

    initial
    begin : result_drain
        int             calm;
        int             w;
        pcsi_pkg::res_t got;
        calm = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            w = pick_wait(calm);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = m_tdata[132:0];
            if (awaited_status.size() == 0)
            begin
                $error("status word with no request outstanding: %h", m_tdata);
                mismatches++;
            end
            else
                compare_status(awaited_status.pop_front(), got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("pcf_clock_sync_integration_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        build_directed();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            push_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

        settle(40);
        apply_config(16'd1024, 16'd0, 32'd10000, 32'd0, 17'd65536, 16'd2, 1'b1);
        run_random(70);
        settle(40);
        apply_config(16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd1, 16'd0, 1'b1);
        run_random(70);
        // zero divisor acts as one
        settle(40);
        apply_config(16'h8000, 16'h7FFF, 32'd0, 32'd12345, 17'd0, 16'hFFFF, 1'b0);
        run_random(70);
        settle(40);
        apply_config(16'hFE00, 16'd37, 32'd1, 32'd500, 17'd3, 16'd1, 1'b1);
        run_random(70);
        settle(40);
        apply_config(16'($urandom), 16'($urandom), $urandom_range(100000, 1), $urandom,
                     17'($urandom_range(65536, 1)), 16'($urandom_range(20, 0)),
                     1'($urandom_range(1, 0)));
        run_random(70);
        settle(40);
        apply_config(16'($urandom), 16'($urandom), $urandom_range(100000, 1), $urandom,
                     17'($urandom_range(65536, 1)), 16'($urandom_range(20, 0)), 1'b1);
        run_random(70);

        settle(50);
        if (mismatches == 0)
            $display("pcf_clock_sync_integration_tb: done, clean");
        else
            $display("pcf_clock_sync_integration_tb: done, errors");
        $finish;
    end

endmodule
